// File: hw/rtl/assert_macros.svh
// assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/lav_pkg.sv
// types and constants of the look-at view matrix block
`timescale 1ns / 1ps
package lav_pkg;

  localparam int N1_CW     = 33;
  localparam int N2_CW     = 64;
  localparam int N1_SIDE_W = 192;
  localparam int N2_SIDE_W = 193;

  localparam logic [1:0] ROW_RIGHT = 2'd0;
  localparam logic [1:0] ROW_UP    = 2'd1;
  localparam logic [1:0] ROW_BACK  = 2'd2;

  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] up_x;
    logic signed [31:0] up_y;
    logic signed [31:0] up_z;
  } lav_in_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic signed [31:0] axis_z;
    logic signed [39:0] translation;
    logic               degenerate;
    logic               last;
  } lav_out_t;

endpackage

// File: hw/rtl/look_at_view_matrix.sv
// top level of the look-at view matrix block
//
//  channel  | direction | handshake               | payload
//  item     | in        | item_valid / item_stall | lav_in_t, eye, target, up
//  row      | out       | row_valid / row_stall   | lav_out_t, one matrix row
//
// a request is taken only when the row port is idle or sends the last of three rows
// 149 register stages from the request to the first row
// (input register, two normalizers, 7 cross and dot stages, row register)
// synchronous reset clears all valid bits; data registers are not reset
// a stall on the row port freezes the whole pipeline, nothing is lost or repeated
`timescale 1ns / 1ps
module look_at_view_matrix (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  lav_pkg::lav_in_t  item,
  output logic              row_valid,
  input  logic              row_stall,
  output lav_pkg::lav_out_t row
);
  import lav_pkg::*;

  logic adv;
  assign item_stall = !adv;

  // input register
  logic    v0;
  lav_in_t in0;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (adv) v0 <= item_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) in0 <= item;
  end

  // back axis
  logic signed [N1_CW-1:0] d [3];
  logic [N1_SIDE_W-1:0]    side1_in, side1_out;
  logic                    n_valid, dn;
  logic signed [31:0]      n [3];
  logic signed [31:0]      e1 [3], up1 [3];

  assign d[0] = N1_CW'(in0.eye_x) - N1_CW'(in0.target_x);
  assign d[1] = N1_CW'(in0.eye_y) - N1_CW'(in0.target_y);
  assign d[2] = N1_CW'(in0.eye_z) - N1_CW'(in0.target_z);
  assign side1_in = {in0.eye_x, in0.eye_y, in0.eye_z, in0.up_x, in0.up_y, in0.up_z};

  lav_norm #(.CW(N1_CW), .SIDE_W(N1_SIDE_W)) u_norm_n (
    .clk, .rst, .en(adv),
    .in_valid(v0), .in_c(d), .in_side(side1_in),
    .out_valid(n_valid), .out_o(n), .out_zero(dn), .out_side(side1_out)
  );

  assign e1[0]  = $signed(side1_out[191:160]);
  assign e1[1]  = $signed(side1_out[159:128]);
  assign e1[2]  = $signed(side1_out[127:96]);
  assign up1[0] = $signed(side1_out[95:64]);
  assign up1[1] = $signed(side1_out[63:32]);
  assign up1[2] = $signed(side1_out[31:0]);

  // up x n products
  logic               vx1;
  logic signed [63:0] px [6];
  logic signed [31:0] ex1 [3], nx1 [3];
  logic               dnx1;

  always_ff @(posedge clk) begin
    if (rst) vx1 <= 1'b0;
    else if (adv) vx1 <= n_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px[0] <= up1[1] * n[2];
      px[1] <= up1[2] * n[1];
      px[2] <= up1[2] * n[0];
      px[3] <= up1[0] * n[2];
      px[4] <= up1[0] * n[1];
      px[5] <= up1[1] * n[0];
      ex1   <= e1;
      nx1   <= n;
      dnx1  <= dn;
    end
  end

  logic               vx2;
  logic signed [63:0] w [3];
  logic signed [31:0] ex2 [3], nx2 [3];
  logic               dnx2;

  always_ff @(posedge clk) begin
    if (rst) vx2 <= 1'b0;
    else if (adv) vx2 <= vx1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w[0] <= px[0] - px[1];
      w[1] <= px[2] - px[3];
      w[2] <= px[4] - px[5];
      ex2  <= ex1;
      nx2  <= nx1;
      dnx2 <= dnx1;
    end
  end

  // right axis
  logic [N2_SIDE_W-1:0] side2_in, side2_out;
  logic                 u_valid, du;
  logic signed [31:0]   u [3];
  logic signed [31:0]   e2 [3], n2 [3];
  logic                 dn2;

  assign side2_in = {ex2[0], ex2[1], ex2[2], nx2[0], nx2[1], nx2[2], dnx2};

  lav_norm #(.CW(N2_CW), .SIDE_W(N2_SIDE_W)) u_norm_u (
    .clk, .rst, .en(adv),
    .in_valid(vx2), .in_c(w), .in_side(side2_in),
    .out_valid(u_valid), .out_o(u), .out_zero(du), .out_side(side2_out)
  );

  assign e2[0] = $signed(side2_out[192:161]);
  assign e2[1] = $signed(side2_out[160:129]);
  assign e2[2] = $signed(side2_out[128:97]);
  assign n2[0] = $signed(side2_out[96:65]);
  assign n2[1] = $signed(side2_out[64:33]);
  assign n2[2] = $signed(side2_out[32:1]);
  assign dn2   = side2_out[0];

  // up axis n x u
  logic               vv1;
  logic signed [63:0] pv [6];
  logic signed [31:0] ev1 [3], nv1 [3], uv1 [3];
  logic               dnv1, duv1;

  always_ff @(posedge clk) begin
    if (rst) vv1 <= 1'b0;
    else if (adv) vv1 <= u_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pv[0] <= n2[1] * u[2];
      pv[1] <= n2[2] * u[1];
      pv[2] <= n2[2] * u[0];
      pv[3] <= n2[0] * u[2];
      pv[4] <= n2[0] * u[1];
      pv[5] <= n2[1] * u[0];
      ev1   <= e2;
      nv1   <= n2;
      uv1   <= u;
      dnv1  <= dn2;
      duv1  <= du;
    end
  end

  logic               vv2;
  logic signed [63:0] cv2 [3];
  logic signed [31:0] ev2 [3], nv2 [3], uv2 [3];
  logic               dnv2, duv2;

  always_ff @(posedge clk) begin
    if (rst) vv2 <= 1'b0;
    else if (adv) vv2 <= vv1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cv2[0] <= pv[0] - pv[1];
      cv2[1] <= pv[2] - pv[3];
      cv2[2] <= pv[4] - pv[5];
      ev2    <= ev1;
      nv2    <= nv1;
      uv2    <= uv1;
      dnv2   <= dnv1;
      duv2   <= duv1;
    end
  end

  logic               vv3;
  logic signed [31:0] vax3 [3];
  logic signed [31:0] ev3 [3], nv3 [3], uv3 [3];
  logic               dnv3, duv3;
  logic signed [63:0] vr [3];
  logic signed [31:0] vc [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vr[i] = (cv2[i] + 64'sd536870912) >>> 30;
      if (vr[i] > 64'sd1073741824) vc[i] = 32'sd1073741824;
      else if (vr[i] < -64'sd1073741824) vc[i] = -32'sd1073741824;
      else vc[i] = vr[i][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vv3 <= 1'b0;
    else if (adv) vv3 <= vv2;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vax3 <= vc;
      ev3  <= ev2;
      nv3  <= nv2;
      uv3  <= uv2;
      dnv3 <= dnv2;
      duv3 <= duv2;
    end
  end

  // translation products
  logic               vd1;
  logic signed [63:0] pd [3][3];
  logic signed [31:0] axd1 [3][3];
  logic               dnd1, dud1;

  always_ff @(posedge clk) begin
    if (rst) vd1 <= 1'b0;
    else if (adv) vd1 <= vv3;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pd[0][i]   <= uv3[i] * ev3[i];
        pd[1][i]   <= vax3[i] * ev3[i];
        pd[2][i]   <= nv3[i] * ev3[i];
        axd1[0][i] <= uv3[i];
        axd1[1][i] <= vax3[i];
        axd1[2][i] <= nv3[i];
      end
      dnd1 <= dnv3;
      dud1 <= duv3;
    end
  end

  logic               vd2;
  logic signed [65:0] sd2 [3];
  logic signed [31:0] axd2 [3][3];
  logic               dnd2, dud2;

  always_ff @(posedge clk) begin
    if (rst) vd2 <= 1'b0;
    else if (adv) vd2 <= vd1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        sd2[r] <= 66'(pd[r][0]) + 66'(pd[r][1]) + 66'(pd[r][2]);
      end
      axd2 <= axd1;
      dnd2 <= dnd1;
      dud2 <= dud1;
    end
  end

  // round, saturate and build the rows
  lav_out_t           rows [3];
  logic signed [65:0] tr [3];
  logic signed [39:0] ts [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      tr[r] = (66'sd536870912 - sd2[r]) >>> 30;
      if (tr[r] > 66'sd549755813887) ts[r] = 40'sd549755813887;
      else if (tr[r] < -66'sd549755813888) ts[r] = -40'sd549755813888;
      else ts[r] = tr[r][39:0];
      rows[r].axis_x      = axd2[r][0];
      rows[r].axis_y      = axd2[r][1];
      rows[r].axis_z      = axd2[r][2];
      rows[r].translation = ts[r];
    end
    rows[0].row_index  = ROW_RIGHT;
    rows[1].row_index  = ROW_UP;
    rows[2].row_index  = ROW_BACK;
    rows[0].degenerate = dud2;
    rows[1].degenerate = dud2;
    rows[2].degenerate = dnd2;
    rows[0].last       = 1'b0;
    rows[1].last       = 1'b0;
    rows[2].last       = 1'b1;
  end

  lav_row_out u_row_out (
    .clk, .rst,
    .in_valid(vd2), .in_rows(rows), .adv,
    .out_valid(row_valid), .out_stall(row_stall), .out_row(row)
  );

endmodule

// File: hw/rtl/lav_norm.sv
// pipelined vector normalizer: scale, square sum, square root, three dividers
`timescale 1ns / 1ps
module lav_norm #(
  parameter int CW     = lav_pkg::N1_CW,
  parameter int SIDE_W = lav_pkg::N1_SIDE_W
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic signed [CW-1:0]     in_c [3],
  input  logic [SIDE_W-1:0]        in_side,
  output logic                     out_valid,
  output logic signed [31:0]       out_o [3],
  output logic                     out_zero,
  output logic [SIDE_W-1:0]        out_side
);
  import lav_pkg::*;

  localparam int SQ_STEPS = 32;
  localparam int DV_STEPS = 31;

  typedef struct packed {
    logic             zero;
    logic [2:0]       neg;
    logic [2:0][30:0] a;
    logic [SIDE_W-1:0] side;
  } sq_carry_t;

  typedef struct packed {
    logic [2:0][31:0] rem;
    logic [2:0][30:0] low;
    logic [2:0][30:0] q;
    logic [31:0]      len;
    logic             zero;
    logic [2:0]       neg;
    logic [SIDE_W-1:0] side;
  } dv_t;

  function automatic logic [5:0] msb_index(input logic [63:0] x);
    logic [5:0] p;
    p = '0;
    for (int b = 0; b < 64; b++) begin
      if (x[b]) p = 6'(b);
    end
    return p;
  endfunction

  // stage 1: magnitudes
  logic              v1;
  logic [CW-1:0]     mag1 [3];
  logic [2:0]        neg1;
  logic [SIDE_W-1:0] side1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg1[i] <= in_c[i][CW-1];
        mag1[i] <= in_c[i][CW-1] ? CW'(-in_c[i]) : CW'(in_c[i]);
      end
      side1 <= in_side;
    end
  end

  // stage 2: largest magnitude
  logic              v2;
  logic [CW-1:0]     mx2;
  logic [CW-1:0]     mag2 [3];
  logic [2:0]        neg2;
  logic [SIDE_W-1:0] side2;
  logic [CW-1:0]     mx_next;

  always_comb begin
    mx_next = mag1[0];
    if (mag1[1] > mx_next) mx_next = mag1[1];
    if (mag1[2] > mx_next) mx_next = mag1[2];
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx2   <= mx_next;
      mag2  <= mag1;
      neg2  <= neg1;
      side2 <= side1;
    end
  end

  // stage 3: leading one
  logic              v3;
  logic [5:0]        p3;
  logic              zero3;
  logic [CW-1:0]     mag3 [3];
  logic [2:0]        neg3;
  logic [SIDE_W-1:0] side3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3    <= msb_index(64'(mx2));
      zero3 <= (mx2 == '0);
      mag3  <= mag2;
      neg3  <= neg2;
      side3 <= side2;
    end
  end

  // stage 4: scale so the largest lies in [2^30, 2^31)
  logic              v4;
  logic [30:0]       a4 [3];
  logic              zero4;
  logic [2:0]        neg4;
  logic [SIDE_W-1:0] side4;
  logic [63:0]       sh [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (p3 > 6'd30) sh[i] = 64'(mag3[i]) >> (p3 - 6'd30);
      else sh[i] = 64'(mag3[i]) << (6'd30 - p3);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) a4[i] <= sh[i][30:0];
      zero4 <= zero3;
      neg4  <= neg3;
      side4 <= side3;
    end
  end

  // stage 5: squares
  logic              v5;
  logic [61:0]       sq5 [3];
  sq_carry_t         c5;

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq5[i]  <= a4[i] * a4[i];
        c5.a[i] <= a4[i];
      end
      c5.zero <= zero4;
      c5.neg  <= neg4;
      c5.side <= side4;
    end
  end

  // square root, one result bit per stage
  logic [63:0] rs_s [0:SQ_STEPS];
  logic [63:0] rs_r [0:SQ_STEPS];
  sq_carry_t   rs_c [0:SQ_STEPS];
  logic        rs_v [0:SQ_STEPS];

  always_ff @(posedge clk) begin
    if (rst) rs_v[0] <= 1'b0;
    else if (en) rs_v[0] <= v5;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rs_s[0] <= 64'(sq5[0]) + 64'(sq5[1]) + 64'(sq5[2]);
      rs_r[0] <= '0;
      rs_c[0] <= c5;
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    logic        ge;
    assign trial = rs_r[k] + BIT;
    assign ge    = (rs_s[k] >= trial);

    always_ff @(posedge clk) begin
      if (rst) rs_v[k+1] <= 1'b0;
      else if (en) rs_v[k+1] <= rs_v[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rs_s[k+1] <= ge ? rs_s[k] - trial : rs_s[k];
        rs_r[k+1] <= ge ? (rs_r[k] >> 1) + BIT : rs_r[k] >> 1;
        rs_c[k+1] <= rs_c[k];
      end
    end
  end

  // restoring division, one quotient bit per stage
  dv_t  dv   [0:DV_STEPS];
  logic dv_v [0:DV_STEPS];
  dv_t  dv_init;

  always_comb begin
    logic [61:0] num;
    dv_init      = '0;
    dv_init.len  = rs_r[SQ_STEPS][31:0];
    dv_init.zero = rs_c[SQ_STEPS].zero;
    dv_init.neg  = rs_c[SQ_STEPS].neg;
    dv_init.side = rs_c[SQ_STEPS].side;
    for (int i = 0; i < 3; i++) begin
      num = 62'({rs_c[SQ_STEPS].a[i], 30'd0}) + 62'(dv_init.len[31:1]);
      dv_init.rem[i] = 32'(num[61:31]);
      dv_init.low[i] = num[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else if (en) dv_v[0] <= rs_v[SQ_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) dv[0] <= dv_init;
  end

  for (genvar j = 0; j < DV_STEPS; j++) begin : g_div
    dv_t nxt;

    always_comb begin
      logic [32:0] t;
      logic [32:0] diff;
      logic        ge;
      nxt = dv[j];
      for (int i = 0; i < 3; i++) begin
        t    = {dv[j].rem[i], dv[j].low[i][DV_STEPS-1-j]};
        diff = t - {1'b0, dv[j].len};
        ge   = (t >= {1'b0, dv[j].len});
        nxt.rem[i] = ge ? diff[31:0] : t[31:0];
        nxt.q[i]   = {dv[j].q[i][29:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) dv_v[j+1] <= 1'b0;
      else if (en) dv_v[j+1] <= dv_v[j];
    end

    always_ff @(posedge clk) begin
      if (en) dv[j+1] <= nxt;
    end
  end

  logic [31:0] qe [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qe[i] = {1'b0, dv[DV_STEPS].q[i]};
      if (dv[DV_STEPS].zero) out_o[i] = '0;
      else if (dv[DV_STEPS].neg[i]) out_o[i] = $signed(-qe[i]);
      else out_o[i] = $signed(qe[i]);
    end
  end

  assign out_valid = dv_v[DV_STEPS];
  assign out_zero  = dv[DV_STEPS].zero;
  assign out_side  = dv[DV_STEPS].side;

endmodule

// File: hw/rtl/lav_row_out.sv
// output register that hands out the three rows of one request
`timescale 1ns / 1ps
module lav_row_out (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  lav_pkg::lav_out_t  in_rows [3],
  output logic               adv,
  output logic               out_valid,
  input  logic               out_stall,
  output lav_pkg::lav_out_t  out_row
);
  import lav_pkg::*;

  logic       busy;
  logic [1:0] cnt;
  lav_out_t   rows [3];

  assign adv = !busy || (!out_stall && cnt == ROW_BACK);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= ROW_RIGHT;
    end else if (adv) begin
      busy <= in_valid;
      cnt  <= ROW_RIGHT;
    end else if (busy && !out_stall) begin
      cnt <= cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) rows <= in_rows;
  end

  assign out_valid = busy;
  assign out_row   = rows[cnt];

endmodule

// File: hw/rtl/lav_checker.sv
// port checker for the look-at view matrix block, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lav_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input logic              row_valid,
  input logic              row_stall,
  input lav_pkg::lav_out_t row
);
  import lav_pkg::*;

  `ASSERT_NEXT(a_row_hold, clk, rst, row_valid && row_stall, row_valid && $stable(row), "stalled row changed")
  `ASSERT_NOW(a_last_flag, clk, rst, row_valid, row.last == (row.row_index == ROW_BACK), "last flag does not match row index")
  `ASSERT_NEXT(a_rows_together, clk, rst, row_valid && !row_stall && !row.last, row_valid && row.row_index == $past(row.row_index) + 2'd1, "rows of a request not consecutive")
  `ASSERT_NOW(a_no_take_mid, clk, rst, row_valid && !row.last, item_stall || !item_valid, "request taken in the middle of a row set")

endmodule

bind look_at_view_matrix lav_checker u_lav_checker (.*);
